>>> hdl/bap_pkg.sv
// Shared types, widths and codes of the block-average pixelation unit.
package bap_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 11;
    localparam int SUM_W      = 20;
    localparam int BSZ_W      = 7;
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int DIV_LANES  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [BSZ_W-1:0] BLOCK_SIZE_RESET   = 7'd8;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    typedef struct packed {
        logic [PIX_W-1:0] blue_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] red_in;
    } bap_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue_mean;
        logic [PIX_W-1:0] green_mean;
        logic [PIX_W-1:0] red_mean;
        logic [POS_W-1:0] block_row;
        logic [POS_W-1:0] block_col;
        logic             frame_done;
    } bap_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_EMIT,
        ST_RECALC_START,
        ST_RECALC_WAIT
    } bap_state_t;

    typedef struct packed {
        logic cfg_write;
        logic capture;
        logic update;
        logic div_start;
        logic div_recalc;
        logic recalc_load;
        logic out_load;
    } bap_cmd_t;

    typedef struct packed {
        logic emit;
        logic div_done;
        logic out_free;
    } bap_status_t;

endpackage

>>> hdl/bap_divider.sv
// Multi-lane restoring divider sharing one divisor, one quotient bit per cycle.
module bap_divider
    import bap_pkg::*;
#(
    parameter int DIV_W = 14
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [DIV_LANES-1:0][SUM_W-1:0]   dividend,
    input  logic [DIV_W-1:0]                  divisor,
    output logic [DIV_LANES-1:0][SUM_W-1:0]   quotient,
    output logic [DIV_LANES-1:0][DIV_W-1:0]   remainder,
    output logic                              done
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [DIV_LANES-1:0][SUM_W-1:0] quo_reg, quo_next;
    logic [DIV_LANES-1:0][DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]                dvs_reg;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            done_reg, done_next;

    always_comb
    begin
        logic [DIV_W:0] trial;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        trial     = '0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(SUM_W);
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            for (int l = 0; l < DIV_LANES; l++)
            begin
                trial = {rem_reg[l], quo_reg[l][SUM_W-1]};
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next[l] = DIV_W'(trial - {1'b0, dvs_reg});
                    quo_next[l] = {quo_reg[l][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[DIV_W-1:0];
                    quo_next[l] = {quo_reg[l][SUM_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> hdl/bap_datapath.sv
// Datapath: configuration, position counters, column sum memory, divider and result register.
module bap_datapath
    import bap_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = 2048,
    parameter int MAX_BLOCK       = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bap_cmd_t              cmd,
    output bap_status_t           status,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  bap_in_t               pixel,
    output logic                  mean_valid,
    input  logic                  mean_stall,
    output bap_out_t              mean
);

    localparam int ADDR_W = $clog2(MAX_LINE_PIXELS);
    localparam int WC_W   = $clog2(MAX_LINE_PIXELS + 1);
    localparam int BS_W   = $clog2(MAX_BLOCK + 1);
    localparam int OFS_W  = $clog2(MAX_BLOCK);
    localparam int DIV_W  = 2 * BS_W;
    localparam int CW     = (WC_W > POS_W + 1) ? WC_W : POS_W + 1;

    // Configuration registers and their clamped forms.
    logic [BSZ_W-1:0] bsz_reg;
    logic [DIM_W-1:0] wid_reg, hgt_reg;
    logic [BS_W-1:0]  bc;
    logic [WC_W-1:0]  wc, hc;
    logic [DIV_W-1:0] area_reg;

    // Position state.
    logic [POS_W-1:0] x_reg, y_reg, bx_reg, by_reg;
    logic [POS_W-1:0] x_next, y_next, bx_next, by_next;
    logic [OFS_W-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic [WC_W-1:0]  cols_reg, rows_reg;

    // Sum memory and per-pixel payload.
    logic [3*SUM_W-1:0] mem [MAX_LINE_PIXELS];
    logic [3*SUM_W-1:0] rd_reg;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W+POS_W-1:0] bx_ext;
    bap_in_t            px_reg;
    logic [SUM_W-1:0]   sb_new, sg_new, sr_new;
    logic [SUM_W-1:0]   sb_reg, sg_reg, sr_reg;
    logic [POS_W-1:0]   row_reg, col_reg;
    logic               fdone_reg;

    logic               crop, first, last, fdone;
    logic [BS_W-1:0]    bm1;

    logic [DIV_LANES-1:0][SUM_W-1:0] div_a, div_q;
    logic [DIV_LANES-1:0][DIV_W-1:0] div_r;
    logic [DIV_W-1:0]                div_d;
    logic                            div_done;

    bap_out_t out_reg, out_next;
    logic     out_valid_reg, out_valid_next;
    logic     out_free;

    always_comb
    begin
        if (bsz_reg == '0)
        begin
            bc = BS_W'(1);
        end
        else if (int'(bsz_reg) > MAX_BLOCK)
        begin
            bc = BS_W'(MAX_BLOCK);
        end
        else
        begin
            bc = BS_W'(bsz_reg);
        end
        if (wid_reg == '0)
        begin
            wc = WC_W'(1);
        end
        else if (int'(wid_reg) > MAX_LINE_PIXELS)
        begin
            wc = WC_W'(MAX_LINE_PIXELS);
        end
        else
        begin
            wc = WC_W'(wid_reg);
        end
        if (hgt_reg == '0)
        begin
            hc = WC_W'(1);
        end
        else if (int'(hgt_reg) > MAX_LINE_PIXELS)
        begin
            hc = WC_W'(MAX_LINE_PIXELS);
        end
        else
        begin
            hc = WC_W'(hgt_reg);
        end
    end

    assign bx_ext = (ADDR_W + POS_W)'(bx_reg);
    assign addr   = bx_ext[ADDR_W-1:0];

    assign crop  = (CW'(bx_reg) < CW'(cols_reg)) && (CW'(by_reg) < CW'(rows_reg));
    assign first = (ox_reg == '0) && (oy_reg == '0);
    assign bm1   = bc - 1'b1;
    assign last  = (BS_W'(ox_reg) == bm1) && (BS_W'(oy_reg) == bm1);
    assign fdone = (CW'(bx_reg) + CW'(1) == CW'(cols_reg))
                && (CW'(by_reg) + CW'(1) == CW'(rows_reg));

    // The first pixel of a block row's block overwrites the column sums.
    assign sb_new = first ? SUM_W'(px_reg.blue_in)
                          : rd_reg[3*SUM_W-1 -: SUM_W] + SUM_W'(px_reg.blue_in);
    assign sg_new = first ? SUM_W'(px_reg.green_in)
                          : rd_reg[2*SUM_W-1 -: SUM_W] + SUM_W'(px_reg.green_in);
    assign sr_new = first ? SUM_W'(px_reg.red_in)
                          : rd_reg[SUM_W-1:0] + SUM_W'(px_reg.red_in);

    // Raster position advance with wrap at line and frame end.
    always_comb
    begin
        x_next  = x_reg;
        y_next  = y_reg;
        bx_next = bx_reg;
        by_next = by_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        if (CW'(x_reg) + CW'(1) >= CW'(wc))
        begin
            x_next  = '0;
            bx_next = '0;
            ox_next = '0;
            if (CW'(y_reg) + CW'(1) >= CW'(hc))
            begin
                y_next  = '0;
                by_next = '0;
                oy_next = '0;
            end
            else
            begin
                y_next = y_reg + 1'b1;
                if (BS_W'(oy_reg) == bm1)
                begin
                    oy_next = '0;
                    by_next = by_reg + 1'b1;
                end
                else
                begin
                    oy_next = oy_reg + 1'b1;
                end
            end
        end
        else
        begin
            x_next = x_reg + 1'b1;
            if (BS_W'(ox_reg) == bm1)
            begin
                ox_next = '0;
                bx_next = bx_reg + 1'b1;
            end
            else
            begin
                ox_next = ox_reg + 1'b1;
            end
        end
    end

    // Divider operands: position recovery after a register change, or block means.
    always_comb
    begin
        if (cmd.div_recalc)
        begin
            div_a[0] = SUM_W'(x_reg);
            div_a[1] = SUM_W'(y_reg);
            div_a[2] = SUM_W'(wc);
            div_a[3] = SUM_W'(hc);
            div_d    = DIV_W'(bc);
        end
        else
        begin
            div_a[0] = sb_reg;
            div_a[1] = sg_reg;
            div_a[2] = sr_reg;
            div_a[3] = '0;
            div_d    = area_reg;
        end
    end

    bap_divider #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_d),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    assign out_free = !out_valid_reg || !mean_stall;

    always_comb
    begin
        out_next            = out_reg;
        out_next.blue_mean  = (div_q[0] > SUM_W'(255)) ? 8'hFF : div_q[0][PIX_W-1:0];
        out_next.green_mean = (div_q[1] > SUM_W'(255)) ? 8'hFF : div_q[1][PIX_W-1:0];
        out_next.red_mean   = (div_q[2] > SUM_W'(255)) ? 8'hFF : div_q[2][PIX_W-1:0];
        out_next.block_row  = row_reg;
        out_next.block_col  = col_reg;
        out_next.frame_done = fdone_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!mean_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_reg <= mem[addr];
            px_reg <= pixel;
        end
        if (cmd.update && crop)
        begin
            mem[addr] <= {sb_new, sg_new, sr_new};
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg <= DIV_W'(bc) * DIV_W'(bc);
        if (cmd.update)
        begin
            sb_reg    <= sb_new;
            sg_reg    <= sg_new;
            sr_reg    <= sr_new;
            row_reg   <= by_reg;
            col_reg   <= bx_reg;
            fdone_reg <= fdone;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsz_reg       <= BLOCK_SIZE_RESET;
            wid_reg       <= FRAME_WIDTH_RESET;
            hgt_reg       <= FRAME_HEIGHT_RESET;
            x_reg         <= '0;
            y_reg         <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            cols_reg      <= '0;
            rows_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.cfg_write)
            begin
                case (cfg_index)
                    CFG_BLOCK_SIZE:   bsz_reg <= cfg_data[BSZ_W-1:0];
                    CFG_FRAME_WIDTH:  wid_reg <= cfg_data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT: hgt_reg <= cfg_data[DIM_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.update)
            begin
                x_reg  <= x_next;
                y_reg  <= y_next;
                bx_reg <= bx_next;
                by_reg <= by_next;
                ox_reg <= ox_next;
                oy_reg <= oy_next;
            end
            if (cmd.recalc_load)
            begin
                bx_reg   <= div_q[0][POS_W-1:0];
                ox_reg   <= div_r[0][OFS_W-1:0];
                by_reg   <= div_q[1][POS_W-1:0];
                oy_reg   <= div_r[1][OFS_W-1:0];
                cols_reg <= div_q[2][WC_W-1:0];
                rows_reg <= div_q[3][WC_W-1:0];
            end
        end
    end

    assign status.emit     = crop && last;
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assign mean_valid = out_valid_reg;
    assign mean       = out_reg;

endmodule

>>> hdl/bap_controller.sv
// Controller state machine sequencing pixel updates, mean division and position recovery.
module bap_controller
    import bap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  bap_status_t status,
    output bap_cmd_t    cmd
);

    bap_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    state_next = ST_RECALC_START;
                end
                else if (pixel_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = status.emit ? ST_MEAN_START : ST_IDLE;
            end
            ST_MEAN_START:
            begin
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RECALC_START:
            begin
                state_next = ST_RECALC_WAIT;
            end
            ST_RECALC_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cfg_ready       = (state_reg == ST_IDLE);
        pixel_stall     = (state_reg != ST_IDLE) || cfg_valid;
        cmd.cfg_write   = (state_reg == ST_IDLE) && cfg_valid;
        cmd.capture     = (state_reg == ST_IDLE) && pixel_valid && !cfg_valid;
        cmd.update      = (state_reg == ST_UPDATE);
        cmd.div_start   = (state_reg == ST_MEAN_START) || (state_reg == ST_RECALC_START);
        cmd.div_recalc  = (state_reg == ST_RECALC_START);
        cmd.recalc_load = (state_reg == ST_RECALC_WAIT) && status.div_done;
        cmd.out_load    = (state_reg == ST_EMIT) && status.out_free;
    end

    // Reset starts with a position recovery pass so the block counters match the registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECALC_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/block_average_pixelate_unit.sv
// A pixel transfer is captured, then folded into the column sums in an update state; a finished
// block's means pass through a mean-start, a divide-wait and an emit state into the output register.
// The three channel means come from a 20-step restoring divider; no new pixel is taken while it runs.
// Reset: asynchronous, active low; registers take their reset values, then a position
// recovery pass runs before pixels are taken; the same pass follows each config write.
// Top level of the block-average pixelation unit.
module block_average_pixelate_unit
    import bap_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = 2048,
    parameter int MAX_BLOCK       = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  bap_in_t               pixel,
    output logic                  mean_valid,
    input  logic                  mean_stall,
    output bap_out_t              mean,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The controller and the datapath talk only through these two groups.
    bap_cmd_t    cmd;
    bap_status_t status;

    // The controller accepts one pixel transfer at a time. A configuration write has
    // priority over a pixel in the same cycle and starts a short divide pass that
    // recovers block column, block row, offsets and block counts from the kept position.
    bap_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // The datapath reads the column sums in the capture cycle and writes them back in the
    // update cycle. A finished block's means go to an output register, so the next pixel
    // is taken while that result waits for its transfer.
    bap_datapath #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .MAX_BLOCK       (MAX_BLOCK)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel),
        .mean_valid (mean_valid),
        .mean_stall (mean_stall),
        .mean       (mean)
    );

endmodule

>>> hdl/bap_checker.sv
// Port-level checker for the block-average pixelation unit and its bind statement.
module bap_checker
    import bap_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pixel_valid,
    input logic                  pixel_stall,
    input bap_in_t               pixel,
    input logic                  mean_valid,
    input logic                  mean_stall,
    input bap_out_t              mean,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // A configuration write never shares its cycle with a pixel transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> pixel_stall)
        else $error("pixel taken in the cycle of a configuration write");

    // After a configuration write the unit is busy recovering its position.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> pixel_stall && !cfg_ready)
        else $error("unit not busy after a configuration write");

    // Each pixel transfer is followed by an update cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> pixel_stall && !cfg_ready)
        else $error("no update cycle after a pixel transfer");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        mean_valid && mean_stall |=> mean_valid && $stable(mean))
        else $error("stalled result changed");

endmodule

bind block_average_pixelate_unit bap_checker u_bap_checker (.*);

>>> bench/block_average_pixelate_unit_test.sv
// Self-checking testbench for the block-average pixelation unit.
module block_average_pixelate_unit_test
    import bap_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LINE       = 2048;
    localparam int MAX_BLK        = 64;
    // Cycles allowed for a pixel still inside the block after its last mean is out.
    localparam int SETTLE_CYCLES  = 60;
    // Cycles without any transfer on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PIXEL_TARGET   = 1100;
    // Register index that maps to no register; the block must ignore the write.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // The scoreboard keeps its own copy of the registers, the per-column channel
    // sums and the raster position, and predicts the block means in order.
    class mean_board;
        logic [BSZ_W-1:0] blk_reg;
        logic [DIM_W-1:0] wid_reg;
        logic [DIM_W-1:0] hgt_reg;
        logic [SUM_W-1:0] sum_b [MAX_LINE];
        logic [SUM_W-1:0] sum_g [MAX_LINE];
        logic [SUM_W-1:0] sum_r [MAX_LINE];
        bit               touched [MAX_LINE];
        int               pos_x;
        int               pos_y;
        bap_out_t         means_due [$];
        int               pixels;
        int               cropped;
        int               means_made;
        int               means_checked;
        int               frames;
        int               errors;

        function new();
            blk_reg = BLOCK_SIZE_RESET;
            wid_reg = FRAME_WIDTH_RESET;
            hgt_reg = FRAME_HEIGHT_RESET;
        endfunction

        static function int clamp_dim(int v, int hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        static function logic [PIX_W-1:0] mean_of(logic [SUM_W-1:0] s, int area);
            int q;
            q = int'(s) / area;
            return (q > 255) ? 8'd255 : PIX_W'(q);
        endfunction

        function int pending();
            return means_due.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BLOCK_SIZE:   blk_reg = data[BSZ_W-1:0];
                CFG_FRAME_WIDTH:  wid_reg = data;
                CFG_FRAME_HEIGHT: hgt_reg = data;
                default: ;
            endcase
        endfunction

        // A new setting never makes the block read a column whose sums were
        // never written: either the frame starts fresh, every pixel starts its
        // own block, or every column in reach has been written already.
        function bit config_safe(int bsz, int wd);
            int b;
            int cols;
            b = clamp_dim(bsz, MAX_BLK);
            cols = clamp_dim(wd, MAX_LINE) / b;
            if ((pos_x == 0 && pos_y == 0) || b == 1)
                return 1;
            for (int k = 0; k < cols; k++)
                if (!touched[k])
                    return 0;
            return 1;
        endfunction

        function void note_pixel(bap_in_t px);
            int b, w, h, cols, rows, x, y, bx, by, ox, oy, k;
            bap_out_t want;
            b = clamp_dim(int'(blk_reg), MAX_BLK);
            w = clamp_dim(int'(wid_reg), MAX_LINE);
            h = clamp_dim(int'(hgt_reg), MAX_LINE);
            cols = w / b;
            rows = h / b;
            x = pos_x;
            y = pos_y;
            pixels++;
            if (x < cols * b && y < rows * b)
            begin
                cropped++;
                bx = x / b;
                ox = x % b;
                by = y / b;
                oy = y % b;
                k = bx % MAX_LINE;
                if (ox == 0 && oy == 0)
                begin
                    sum_b[k] = SUM_W'(px.blue_in);
                    sum_g[k] = SUM_W'(px.green_in);
                    sum_r[k] = SUM_W'(px.red_in);
                    touched[k] = 1'b1;
                end
                else
                begin
                    sum_b[k] = sum_b[k] + SUM_W'(px.blue_in);
                    sum_g[k] = sum_g[k] + SUM_W'(px.green_in);
                    sum_r[k] = sum_r[k] + SUM_W'(px.red_in);
                end
                if (ox == b - 1 && oy == b - 1)
                begin
                    want.blue_mean  = mean_of(sum_b[k], b * b);
                    want.green_mean = mean_of(sum_g[k], b * b);
                    want.red_mean   = mean_of(sum_r[k], b * b);
                    want.block_row  = POS_W'(by);
                    want.block_col  = POS_W'(bx);
                    want.frame_done = (bx == cols - 1 && by == rows - 1);
                    means_due.insert(means_due.size(), want);
                    means_made++;
                end
            end
            if (x + 1 >= w)
            begin
                pos_x = 0;
                if (y + 1 >= h)
                begin
                    pos_y = 0;
                    frames++;
                end
                else
                    pos_y = y + 1;
            end
            else
                pos_x = x + 1;
        endfunction

        function void compare(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_mean(bap_out_t got);
            bap_out_t want;
            if (means_due.size() == 0)
            begin
                $error("block mean with nothing outstanding: row %0d col %0d",
                       got.block_row, got.block_col);
                errors++;
                return;
            end
            want = means_due.pop_front();
            means_checked++;
            compare("blue_mean",  want.blue_mean,  got.blue_mean);
            compare("green_mean", want.green_mean, got.green_mean);
            compare("red_mean",   want.red_mean,   got.red_mean);
            compare("block_row",  want.block_row,  got.block_row);
            compare("block_col",  want.block_col,  got.block_col);
            compare("frame_done", want.frame_done, got.frame_done);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    bap_in_t               pixel       = '0;
    logic                  mean_valid;
    logic                  mean_stall  = 1'b0;
    bap_out_t              mean;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    mean_board board = new();

    // Idle rates in percent for the pixel sender and the mean receiver.
    int gap_pct = 0;
    int stall_pct = 0;
    int settings_done = 0;

    block_average_pixelate_unit #(
        .MAX_LINE_PIXELS(MAX_LINE),
        .MAX_BLOCK      (MAX_BLK)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel      (pixel),
        .mean_valid (mean_valid),
        .mean_stall (mean_stall),
        .mean       (mean),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge clk)
        mean_stall <= ($urandom_range(0, 99) < stall_pct);

    // Every mean transfer is checked against the oldest outstanding prediction.
    // Values are read at the edge, before any update scheduled for it lands.
    always @(posedge clk)
        if (rst_n && mean_valid && !mean_stall)
            board.check_mean(mean);

    // Watchdog: the run is hung once no channel has moved a transfer for a
    // long stretch. The slowest legal stretch is a recovery pass after a
    // register write or a long random stall, both far below the limit.
    initial
    begin : watchdog
        int quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (mean_valid && !mean_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timed out after %0d cycles without a transfer", WATCHDOG_LIMIT);
        $display("FAIL block_average_pixelate_unit");
        $finish;
    end

    function automatic bap_in_t rgb(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        rgb = '{blue_in: b, green_in: g, red_in: r};
    endfunction

    function automatic bap_in_t rand_pixel();
        logic [23:0] raw;
        raw = 24'($urandom);
        return bap_in_t'(raw);
    endfunction

    task automatic set_idling(int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 88; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 88; end
            default: begin gap_pct = 38; stall_pct = 38; end
        endcase
    endtask

    // One pixel transfer, with an optional random gap in front of it. Valid is
    // only assigned once per edge, so a back-to-back pixel keeps it high.
    task automatic send_pixel(bap_in_t px);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            pixel_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < gap_pct);
        end
        pixel       <= px;
        pixel_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pixel_stall);
        board.note_pixel(px);
    endtask

    // The sender holds off until every predicted mean has come out.
    task automatic drain_pause();
        pixel_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (board.pending() != 0);
    endtask

    // Brings the block to rest: all means out, then room for a pixel that is
    // still being folded into the sums and produces no mean.
    task automatic settle();
        pixel_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        board.set_reg(idx, CFG_DATA_W'(value));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A new setting of all three registers, written while the block is at rest.
    // Each setting also moves the run on to the next idling pattern.
    task automatic program_frame(int bsz, int wd, int ht);
        settle();
        write_reg(CFG_BLOCK_SIZE, bsz);
        write_reg(CFG_FRAME_WIDTH, wd);
        write_reg(CFG_FRAME_HEIGHT, ht);
        set_idling(settings_done % 4);
        settings_done++;
    endtask

    // One random phase. Most phases use small frames and run until whole
    // frames have passed, so the position counters come back to the origin.
    // The rest use extreme register values or stop mid-frame, which leaves the
    // counters somewhere odd for the next setting to pick up.
    task automatic run_random_phase();
        int  kind;
        int  bsz;
        int  wd;
        int  ht;
        int  tries;
        int  target;
        int  sent;
        bit  pause_here;
        kind = $urandom_range(0, 9);
        tries = 0;
        do
        begin
            if (kind == 8)
            begin
                case ($urandom_range(0, 3))
                    0: bsz = 0;
                    1: bsz = MAX_BLK;
                    2: bsz = $urandom_range(MAX_BLK + 1, 127);
                    default: bsz = $urandom_range(1, MAX_BLK);
                endcase
                case ($urandom_range(0, 3))
                    0: wd = 0;
                    1: wd = MAX_LINE;
                    2: wd = $urandom_range(MAX_LINE + 1, 4095);
                    default: wd = $urandom_range(1, MAX_LINE - 1);
                endcase
                case ($urandom_range(0, 3))
                    0: ht = 0;
                    1: ht = MAX_LINE;
                    2: ht = $urandom_range(MAX_LINE + 1, 4095);
                    default: ht = $urandom_range(1, 8);
                endcase
            end
            else
            begin
                bsz = $urandom_range(1, 4);
                wd  = $urandom_range(1, 24);
                ht  = $urandom_range(1, 12);
            end
            tries++;
        end
        while (!board.config_safe(bsz, wd) && tries < 32);
        // Single-pixel blocks always start fresh, so they are the fallback.
        if (!board.config_safe(bsz, wd))
            bsz = 1;
        program_frame(bsz, wd, ht);
        pause_here = (settings_done % 5 == 2);
        sent = 0;
        if (kind < 8)
        begin
            target = board.frames + $urandom_range(1, 3);
            while (board.frames < target && board.pixels < PIXEL_TARGET)
            begin
                if (pause_here && sent == 4)
                    drain_pause();
                send_pixel(rand_pixel());
                sent++;
            end
        end
        else
            repeat ($urandom_range(1, 40)) send_pixel(rand_pixel());
    endtask

    initial
    begin
        set_idling(0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A few pixels under the reset setting (8-pixel blocks on 640 x 480).
        // They start block column 0 but complete nothing.
        send_pixel(rgb(8'h00, 8'h00, 8'h00));
        send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
        send_pixel(rgb(8'h55, 8'hAA, 8'h0F));

        // A write to an index with no register behind it changes nothing.
        settle();
        write_reg(CFG_UNUSED, 12'hFFF);

        // Single-pixel blocks on an 8 x 1 frame, entered mid-line: every pixel
        // is its own mean. This also seeds the sums of the first columns so
        // that later settings changed mid-frame only read written columns.
        program_frame(1, 8, 1);
        for (int i = 0; i < 13; i++)
        begin
            if (i == 5)
                drain_pause();
            case (i % 4)
                0: send_pixel(rgb(8'h00, 8'h00, 8'h00));
                1: send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
                2: send_pixel(rgb(8'h80, 8'h01, 8'h7F));
                default: send_pixel(rand_pixel());
            endcase
        end

        // Zero in every register reads as one: a 1 x 1 frame of 1-pixel blocks.
        program_frame(0, 0, 0);
        send_pixel(rand_pixel());
        send_pixel(rgb(8'hFF, 8'h00, 8'hFF));

        // Mean overflow: four white pixels summed as part of a 3-pixel block,
        // then the block size drops to 2 while the counters sit at (1, 1). The
        // next pixel closes a 2-pixel block over five pixels' worth of sum, so
        // the mean saturates. The rest of the 3 x 3 frame is cropped away.
        program_frame(3, 3, 3);
        repeat (4) send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
        program_frame(2, 3, 3);
        send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
        repeat (4) send_pixel(rand_pixel());

        // Largest sizes: a one-pixel-wide strip with an oversized height walks
        // the counters down to line 63, then an oversized block size (held at
        // the maximum) on a 64 x 64 frame finishes a whole block in one line.
        program_frame(1, 1, 4095);
        repeat (63) send_pixel(rand_pixel());
        program_frame(127, 64, 64);
        repeat (64) send_pixel(rand_pixel());

        while (board.pixels < PIXEL_TARGET)
            run_random_phase();

        // Let every outstanding mean come out, then watch for any stray one.
        settle();

        $display("Covered %0d pixel transfers (%0d inside the cropped frame) over %0d settings,",
                 board.pixels, board.cropped, settings_done);
        $display("with %0d block means checked and %0d frames wrapped; %0d mismatches.",
                 board.means_checked, board.frames, board.errors);
        if (board.errors == 0)
            $display("PASS block_average_pixelate_unit");
        else
            $display("FAIL block_average_pixelate_unit");
        $finish;
    end

endmodule
